[hdl/smap_pkg.sv]
// shared types and constants for the soil moisture average percent block
package smap_pkg;

  // field widths
  localparam int unsigned LEVEL_W = 12;
  localparam int unsigned PCT_W   = 7;

  // full scale of the calibrated output
  localparam logic [PCT_W-1:0] FULL_SCALE = 7'd100;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DRY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WET = 1'b1;

  // reset values of the calibration levels
  localparam logic [LEVEL_W-1:0] DRY_RESET = 12'd4095;
  localparam logic [LEVEL_W-1:0] WET_RESET = 12'd0;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // request from the front into the queue
  typedef struct packed {
    logic               vld;
    logic [LEVEL_W-1:0] mean;
  } q_req_t;

endpackage

[hdl/soil_moisture_average_percent.sv]
// top level: moving average of soil moisture samples mapped to percent
//
// Each accepted raw_sample replaces the oldest of the last WINDOW_LEN samples
// (the window starts out as zeros after reset, with no clearing pass) and
// yields one result: the truncated window mean, that mean mapped linearly from
// dry_level (0 percent) to wet_level (100 percent) and clamped to 0..100, and a
// fault flag when both levels are equal, in which case the percent is 0. The
// front handles one sample at a time (ring read, sum update, reciprocal
// multiply, push into a two-entry queue) and is busy until the push; the back
// maps one queued mean at a time, running the 7-step serial divider only when
// the ratio lies strictly between 0 and full scale, so results that need the
// divide make the back, not the front, limit the sample rate. Write the
// calibration levels only while no sample is in flight.
module soil_moisture_average_percent #(
  parameter int unsigned WINDOW_LEN = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [smap_pkg::LEVEL_W-1:0]   raw_sample_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [smap_pkg::LEVEL_W-1:0]   mean_level_o,
  output logic [smap_pkg::PCT_W-1:0]     moisture_percent_o,
  output logic                           calibration_fault_o,
  input  logic                           cfg_we_i,
  input  logic [smap_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [smap_pkg::LEVEL_W-1:0]   cfg_data_i
);

  logic                         front_busy;
  logic                         accept;
  smap_pkg::q_req_t             q_req;
  logic                         q_full, q_empty, q_pop;
  logic [smap_pkg::LEVEL_W-1:0] q_mean;
  logic [smap_pkg::LEVEL_W-1:0] dry_q, wet_q;

  // calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_q <= smap_pkg::DRY_RESET;
      wet_q <= smap_pkg::WET_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        smap_pkg::REG_DRY: dry_q <= cfg_data_i;
        smap_pkg::REG_WET: wet_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // input request taken when front is free and the queue has room
  assign full   = front_busy || q_full;
  assign accept = push && !full;

  smap_front #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .raw_sample_i(raw_sample_i),
    .busy_o      (front_busy),
    .q_o         (q_req)
  );

  smap_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (q_req),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .mean_o (q_mean)
  );

  smap_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_empty_i          (q_empty),
    .q_mean_i           (q_mean),
    .q_pop_o            (q_pop),
    .dry_i              (dry_q),
    .wet_i              (wet_q),
    .empty_o            (empty),
    .pop_i              (pop),
    .mean_level_o       (mean_level_o),
    .moisture_percent_o (moisture_percent_o),
    .calibration_fault_o(calibration_fault_o)
  );

endmodule

[hdl/smap_front.sv]
// front part: sample ring, running sum and mean by reciprocal multiply
module smap_front #(
  parameter int unsigned WINDOW_LEN = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [smap_pkg::LEVEL_W-1:0] raw_sample_i,
  output logic                         busy_o,
  output smap_pkg::q_req_t             q_o
);

  localparam int unsigned L    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 0;
  localparam int unsigned POSW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned SUMW = smap_pkg::LEVEL_W + L;
  localparam int unsigned SHR  = SUMW + L;
  localparam int unsigned MW   = SUMW + 1;
  localparam int unsigned PW   = SUMW + MW;
  localparam longint unsigned MULT = ((64'd1 << SHR) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam logic [MW-1:0] MULT_C = MW'(MULT);
  localparam logic [POSW-1:0] POS_LAST = POSW'(WINDOW_LEN - 1);

  typedef enum logic [1:0] {FR_IDLE, FR_READ, FR_MUL, FR_PUSH} state_e;

  state_e                       state_q;
  logic [POSW-1:0]              pos_q;
  logic [SUMW-1:0]              sum_q, sum_d;
  logic [WINDOW_LEN-1:0]        vld_q;
  logic [smap_pkg::LEVEL_W-1:0] smp_q;
  logic [smap_pkg::LEVEL_W-1:0] rd_q;
  logic [smap_pkg::LEVEL_W-1:0] old_smp;
  logic [PW-1:0]                prod_q;
  logic [smap_pkg::LEVEL_W-1:0] ring_q [WINDOW_LEN];

  // ring memory, registered read of the oldest entry
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd_q  <= ring_q[pos_q];
      smp_q <= raw_sample_i;
    end
    if (state_q == FR_READ) begin
      ring_q[pos_q] <= smp_q;
    end
  end

  // entries never written read as zero
  assign old_smp = vld_q[pos_q] ? rd_q : '0;
  assign sum_d   = sum_q - SUMW'(old_smp) + SUMW'(smp_q);

  // sequencer, sum and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      pos_q   <= '0;
      sum_q   <= '0;
      vld_q   <= '0;
    end else begin
      case (state_q)
        FR_IDLE: begin
          if (accept_i) begin
            state_q <= FR_READ;
          end
        end
        FR_READ: begin
          sum_q        <= sum_d;
          vld_q[pos_q] <= 1'b1;
          pos_q        <= (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
          state_q      <= FR_MUL;
        end
        FR_MUL: begin
          state_q <= FR_PUSH;
        end
        FR_PUSH: begin
          state_q <= FR_IDLE;
        end
        default: begin
          state_q <= FR_IDLE;
        end
      endcase
    end
  end

  // sum times reciprocal of the window length
  always_ff @(posedge clk_i) begin
    if (state_q == FR_MUL) begin
      prod_q <= PW'(sum_q) * PW'(MULT_C);
    end
  end

  assign busy_o = (state_q != FR_IDLE);
  assign q_o.vld  = (state_q == FR_PUSH);
  assign q_o.mean = prod_q[SHR +: smap_pkg::LEVEL_W];

endmodule

[hdl/smap_queue.sv]
// short queue of mean levels between front and back
module smap_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  smap_pkg::q_req_t             q_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic [smap_pkg::LEVEL_W-1:0] mean_o
);

  logic [smap_pkg::LEVEL_W-1:0] mem_q [smap_pkg::QDEPTH];
  logic [smap_pkg::QPTR_W-1:0]  wr_q, rd_q;
  logic [smap_pkg::QCNT_W-1:0]  cnt_q;
  logic                         do_push, do_pop;

  assign full_o  = (cnt_q == smap_pkg::QCNT_W'(smap_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = q_i.vld && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign mean_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= q_i.mean;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // fill count never passes the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= smap_pkg::QCNT_W'(smap_pkg::QDEPTH))
    else $error("queue count out of range");

  // front only pushes when room was reserved at accept
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_i.vld |-> !full_o)
    else $error("request pushed into full queue");

endmodule

[hdl/smap_back.sv]
// back part: calibration map with a serial divider and result register
module smap_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  logic [smap_pkg::LEVEL_W-1:0] q_mean_i,
  output logic                         q_pop_o,
  input  logic [smap_pkg::LEVEL_W-1:0] dry_i,
  input  logic [smap_pkg::LEVEL_W-1:0] wet_i,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [smap_pkg::LEVEL_W-1:0] mean_level_o,
  output logic [smap_pkg::PCT_W-1:0]   moisture_percent_o,
  output logic                         calibration_fault_o
);

  localparam int unsigned LW   = smap_pkg::LEVEL_W;
  localparam int unsigned PW   = smap_pkg::PCT_W;
  localparam int unsigned DVW  = LW + PW;
  localparam int unsigned CNTW = $clog2(PW);

  typedef enum logic [1:0] {BK_IDLE, BK_PREP, BK_DIV, BK_HOLD} state_e;

  state_e               state_q;
  logic [LW-1:0]        avg_q;
  logic                 fault_q;
  logic [PW-1:0]        quo_q;
  logic [LW-1:0]        rem_q;
  logic [LW-1:0]        span_q;
  logic [PW-1:0]        dvd_q;
  logic [CNTW-1:0]      cnt_q;
  logic                 out_vld_q;
  logic [LW-1:0]        out_mean_q;
  logic [PW-1:0]        out_pct_q;
  logic                 out_fault_q;

  logic signed [LW:0]   diff, span;
  logic [LW-1:0]        diff_abs, span_abs;
  logic [DVW-1:0]       scaled;
  logic                 opp_sign;
  logic [LW:0]          trial;
  logic                 ge;
  logic                 load_out;

  // signed distances from the dry level
  assign diff     = $signed({1'b0, avg_q}) - $signed({1'b0, dry_i});
  assign span     = $signed({1'b0, wet_i}) - $signed({1'b0, dry_i});
  assign diff_abs = diff[LW] ? LW'(-diff) : diff[LW-1:0];
  assign span_abs = span[LW] ? LW'(-span) : span[LW-1:0];
  assign opp_sign = diff[LW] ^ span[LW];
  assign scaled   = DVW'(diff_abs) * DVW'(smap_pkg::FULL_SCALE);

  // one restoring step of the divide
  assign trial = {rem_q, dvd_q[cnt_q]};
  assign ge    = (trial >= {1'b0, span_q});

  assign q_pop_o = (state_q == BK_IDLE) && !q_empty_i;

  // finished result moves into the output register when it is free or being taken
  assign load_out = (state_q == BK_HOLD) && (!out_vld_q || pop_i);

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_vld_q   <= 1'b0;
      avg_q       <= '0;
      fault_q     <= 1'b0;
      quo_q       <= '0;
      rem_q       <= '0;
      span_q      <= '0;
      dvd_q       <= '0;
      cnt_q       <= '0;
      out_mean_q  <= '0;
      out_pct_q   <= '0;
      out_fault_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        BK_IDLE: begin
          if (!q_empty_i) begin
            avg_q   <= q_mean_i;
            state_q <= BK_PREP;
          end
        end
        BK_PREP: begin
          fault_q <= (span == '0);
          if (span == '0 || diff == '0 || opp_sign) begin
            // zero span, zero distance or negative ratio
            quo_q   <= '0;
            state_q <= BK_HOLD;
          end else if (diff_abs >= span_abs) begin
            // ratio of one or more clamps to full scale
            quo_q   <= smap_pkg::FULL_SCALE;
            state_q <= BK_HOLD;
          end else begin
            rem_q   <= scaled[DVW-1:PW];
            dvd_q   <= scaled[PW-1:0];
            span_q  <= span_abs;
            quo_q   <= '0;
            cnt_q   <= CNTW'(PW - 1);
            state_q <= BK_DIV;
          end
        end
        BK_DIV: begin
          rem_q <= ge ? LW'(trial - {1'b0, span_q}) : trial[LW-1:0];
          quo_q <= {quo_q[PW-2:0], ge};
          if (cnt_q == '0) begin
            state_q <= BK_HOLD;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        BK_HOLD: begin
          if (load_out) begin
            out_mean_q  <= avg_q;
            out_pct_q   <= quo_q;
            out_fault_q <= fault_q;
            state_q     <= BK_IDLE;
          end
        end
        default: begin
          state_q <= BK_IDLE;
        end
      endcase
    end
  end

  assign empty_o             = !out_vld_q;
  assign mean_level_o        = out_mean_q;
  assign moisture_percent_o  = out_pct_q;
  assign calibration_fault_o = out_fault_q;

  // shown percent stays within full scale
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> moisture_percent_o <= smap_pkg::FULL_SCALE)
    else $error("percent above full scale");

  // a calibration fault always reports zero percent
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && calibration_fault_o) |-> moisture_percent_o == '0)
    else $error("fault with nonzero percent");

  // divide only runs with a nonzero divisor and a remainder below it
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DIV |-> (span_q != '0 && rem_q < span_q))
    else $error("divider out of range");

endmodule

[verif/soil_moisture_average_percent_test.sv]
// testbench for the soil moisture moving average and percent calibration block
module soil_moisture_average_percent_test;

  localparam int unsigned WINDOW = 8;
  localparam int unsigned POS_W = $clog2(WINDOW);
  localparam int unsigned MAX_SHOWN = 10;
  localparam int unsigned SETTLE_CYCLES = 30;

  // one expected result of the block
  typedef struct {
    logic [smap_pkg::LEVEL_W-1:0] mean;
    logic [smap_pkg::PCT_W-1:0]   pct;
    logic                         fault;
  } reading_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           push;
  logic                           full;
  logic [smap_pkg::LEVEL_W-1:0]   raw_sample_i;
  logic                           empty;
  logic                           pop;
  logic [smap_pkg::LEVEL_W-1:0]   mean_level_o;
  logic [smap_pkg::PCT_W-1:0]     moisture_percent_o;
  logic                           calibration_fault_o;
  logic                           cfg_we_i;
  logic [smap_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [smap_pkg::LEVEL_W-1:0]   cfg_data_i;

  // model state of the averaging window and the calibration
  logic [smap_pkg::LEVEL_W-1:0] window_ring [WINDOW];
  logic [POS_W-1:0]             window_pos;
  int unsigned                  window_sum;
  logic [smap_pkg::LEVEL_W-1:0] cal_dry;
  logic [smap_pkg::LEVEL_W-1:0] cal_wet;
  reading_t                     pending_readings [$];

  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned pop_stall_pct;
  int unsigned pop_hold_left;

  soil_moisture_average_percent #(
    .WINDOW_LEN(WINDOW)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .raw_sample_i       (raw_sample_i),
    .empty              (empty),
    .pop                (pop),
    .mean_level_o       (mean_level_o),
    .moisture_percent_o (moisture_percent_o),
    .calibration_fault_o(calibration_fault_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("soil_moisture_average_percent_test: errors");
    $finish;
  end

  // window update and calibration map for one accepted sample
  task automatic predict_reading(input logic [smap_pkg::LEVEL_W-1:0] raw);
    int       diff;
    int       span;
    int       pct;
    reading_t r;
    window_sum = window_sum - 32'(window_ring[window_pos]) + 32'(raw);
    window_ring[window_pos] = raw;
    window_pos = (window_pos == POS_W'(WINDOW - 1)) ? '0 : window_pos + 1'b1;
    r.mean = smap_pkg::LEVEL_W'(window_sum / WINDOW);
    diff = int'(r.mean) - int'(cal_dry);
    span = int'(cal_wet) - int'(cal_dry);
    if (span == 0) begin
      r.fault = 1'b1;
      pct = 0;
    end else begin
      r.fault = 1'b0;
      pct = (diff * 100) / span;
      if (pct < 0) pct = 0;
      if (pct > int'(smap_pkg::FULL_SCALE)) pct = int'(smap_pkg::FULL_SCALE);
    end
    r.pct = smap_pkg::PCT_W'(pct);
    pending_readings.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    error_count++;
    if (error_count <= MAX_SHOWN)
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
  endtask

  // one sample request, with random idle cycles ahead of it
  task automatic send_sample(input logic [smap_pkg::LEVEL_W-1:0] raw);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    raw_sample_i <= raw;
    do @(posedge clk_i); while (full);
    predict_reading(raw);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  // wait until every expected result has been taken, then let the block settle
  task automatic drain();
    stop_sending();
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_level(input logic [smap_pkg::CFG_IDX_W-1:0] idx,
                             input logic [smap_pkg::LEVEL_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == smap_pkg::REG_DRY) cal_dry = value;
    else cal_wet = value;
  endtask

  task automatic set_calibration(input logic [smap_pkg::LEVEL_W-1:0] dry,
                                 input logic [smap_pkg::LEVEL_W-1:0] wet);
    drain();
    write_level(smap_pkg::REG_DRY, dry);
    write_level(smap_pkg::REG_WET, wet);
  endtask

  // receiver: random stalls, and long hold-offs counted here
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop_hold_left > 0) begin
      pop <= 1'b0;
      pop_hold_left = pop_hold_left - 1;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    reading_t r;
    if (rst_ni && pop && !empty) begin
      if (pending_readings.size() == 0) begin
        error_count++;
        if (error_count <= MAX_SHOWN)
          $display("unexpected result: mean %0d percent %0d fault %0d",
                   mean_level_o, moisture_percent_o, calibration_fault_o);
      end else begin
        r = pending_readings.pop_front();
        if (mean_level_o !== r.mean)
          report_mismatch("mean_level", 32'(r.mean), 32'(mean_level_o));
        if (moisture_percent_o !== r.pct)
          report_mismatch("moisture_percent", 32'(r.pct), 32'(moisture_percent_o));
        if (calibration_fault_o !== r.fault)
          report_mismatch("calibration_fault", 32'(r.fault), 32'(calibration_fault_o));
      end
    end
  end

  // warm-up from zeros and the extremes under the reset calibration
  task automatic test_reset_calibration();
    send_sample(12'd0);
    send_sample(12'd4095);
    repeat (7) send_sample(12'd4095);
    send_sample(12'd0);
  endtask

  // equal levels raise the fault and force zero percent
  task automatic test_equal_levels();
    set_calibration(12'd2000, 12'd2000);
    send_sample(12'd0);
    send_sample(12'd4095);
    set_calibration(12'd0, 12'd0);
    send_sample(12'd0);
    set_calibration(12'd4095, 12'd4095);
    send_sample(12'd4095);
  endtask

  // dry below wet: full range, then a narrow span that clamps at full scale
  task automatic test_rising_calibration();
    set_calibration(12'd0, 12'd4095);
    repeat (4) send_sample(12'd4095);
    repeat (4) send_sample(12'd0);
    set_calibration(12'd1000, 12'd1001);
    send_sample(12'd2048);
  endtask

  // long receiver hold-off while samples keep coming, so the input stalls
  task automatic test_backpressure();
    drain();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    pop_hold_left = 200;
    repeat (30) send_sample(smap_pkg::LEVEL_W'($urandom));
    drain();
  endtask

  // random samples: level bursts that steer the mean, mixed with noise
  task automatic test_random_phase(input int unsigned items, input int unsigned idle,
                                   input int unsigned stall);
    logic [smap_pkg::LEVEL_W-1:0] dry;
    logic [smap_pkg::LEVEL_W-1:0] wet;
    int unsigned                  lo;
    int unsigned                  hi;
    int unsigned                  target;
    int unsigned                  burst;
    int                           v;
    int unsigned                  n;
    case ($urandom_range(4))
      0: begin
        dry = 12'd4095;
        wet = 12'd0;
      end
      1: begin
        dry = 12'd0;
        wet = 12'd4095;
      end
      2: begin
        dry = smap_pkg::LEVEL_W'($urandom);
        wet = smap_pkg::LEVEL_W'($urandom);
      end
      3: begin
        dry = smap_pkg::LEVEL_W'($urandom);
        wet = dry;
      end
      default: begin
        dry = smap_pkg::LEVEL_W'($urandom_range(3995, 100));
        wet = dry + smap_pkg::LEVEL_W'($urandom_range(200)) - smap_pkg::LEVEL_W'(100);
      end
    endcase
    set_calibration(dry, wet);
    send_idle_pct = idle;
    pop_stall_pct = stall;
    lo = (dry < wet) ? 32'(dry) : 32'(wet);
    hi = (dry < wet) ? 32'(wet) : 32'(dry);
    n = 0;
    while (n < items) begin
      if ($urandom_range(3) == 0) begin
        send_sample(smap_pkg::LEVEL_W'($urandom));
        n++;
      end else begin
        target = $urandom_range(hi, lo);
        burst = $urandom_range(12, 1);
        repeat (burst) begin
          v = int'(target) + int'($urandom_range(80)) - 40;
          if (v < 0) v = 0;
          if (v > 4095) v = 4095;
          send_sample(smap_pkg::LEVEL_W'(v));
          n++;
        end
      end
    end
  endtask

  initial begin
    error_count = 0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    pop_hold_left = 0;
    for (int i = 0; i < WINDOW; i++) window_ring[i] = '0;
    window_pos = '0;
    window_sum = 0;
    cal_dry = smap_pkg::DRY_RESET;
    cal_wet = smap_pkg::WET_RESET;
    rst_ni = 1'b0;
    push = 1'b0;
    raw_sample_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = smap_pkg::REG_DRY;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_calibration();
    test_equal_levels();
    test_rising_calibration();
    test_backpressure();
    test_random_phase(285, 0, 0);
    test_random_phase(285, 57, 0);
    test_random_phase(285, 0, 57);
    test_random_phase(285, 8, 8);

    drain();
    if (pending_readings.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("soil_moisture_average_percent_test: clean");
    end else begin
      $display("soil_moisture_average_percent_test: errors");
    end
    $finish;
  end

endmodule
